// ===== hdl/isotp_pkg.sv =====
`default_nettype none
package isotp_pkg;

	// input command codes
	localparam logic CMD_FRAME = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	// protocol control nibble (upper half of byte 0)
	localparam logic [3:0] PCI_SF = 4'h0;
	localparam logic [3:0] PCI_FF = 4'h1;
	localparam logic [3:0] PCI_CF = 4'h2;
	localparam logic [3:0] PCI_FC = 4'h3;

	localparam logic [7:0] SID_NEGATIVE   = 8'h7F;
	localparam logic [7:0] SID_POS_OFFSET = 8'h40;
	localparam logic [3:0] MAX_FRAME_LEN  = 4'd8;

	// message status codes
	typedef enum logic [2:0] {
		ST_RUNNING      = 3'd0,
		ST_POSITIVE     = 3'd1,
		ST_NEGATIVE     = 3'd2,
		ST_LENGTH_ERROR = 3'd3,
		ST_TIMEOUT      = 3'd4
	} status_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_RESP_ID = 2'd0,
		CFG_REQ_SID = 2'd1,
		CFG_LIMIT   = 2'd2,
		CFG_TIMEOUT = 2'd3
	} cfg_index_t;

	localparam logic [11:0] LIMIT_RESET   = 12'd4095;
	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

	typedef struct packed {
		logic [28:0] resp_id;
		logic [7:0]  req_sid;
		logic [11:0] limit;
		logic [15:0] timeout;
	} cfg_t;

	// one unit of output work: nbytes payload words, or one bare status word when zero
	typedef struct packed {
		logic [2:0]      nbytes;
		logic [6:0][7:0] data;
		logic [11:0]     base;
		logic            fc;
		logic            msg_end;
		status_t         status;
	} job_t;

endpackage
`default_nettype wire

// ===== hdl/isotp_ifs.sv =====
`default_nettype none
interface isotp_item_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [28:0] frame_identifier;
	logic [3:0]  frame_length;
	logic [7:0]  byte0;
	logic [7:0]  byte1;
	logic [7:0]  byte2;
	logic [7:0]  byte3;
	logic [7:0]  byte4;
	logic [7:0]  byte5;
	logic [7:0]  byte6;
	logic [7:0]  byte7;

	modport source (
		output valid, command, frame_identifier, frame_length,
		output byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7,
		input  ready
	);
	modport sink (
		input  valid, command, frame_identifier, frame_length,
		input  byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7,
		output ready
	);
endinterface

interface isotp_result_if;
	logic        valid;
	logic        ready;
	logic        byte_valid;
	logic [7:0]  payload_byte;
	logic [11:0] payload_index;
	logic        flow_control_request;
	logic        message_end;
	logic [2:0]  message_status;
	logic        run_last;

	modport source (
		output valid, byte_valid, payload_byte, payload_index,
		output flow_control_request, message_end, message_status, run_last,
		input  ready
	);
	modport sink (
		input  valid, byte_valid, payload_byte, payload_index,
		input  flow_control_request, message_end, message_status, run_last,
		output ready
	);
endinterface
`default_nettype wire

// ===== hdl/isotp_rx_reassembler_core.sv =====
// Flow: an accepted frame or tick is decoded into at most one job, which is
//   written into the job queue; the back end registers each result word of the head job.
// Throughput: one input per cycle while the job queue has room; the output side
//   gives one word per cycle while the result sink is ready.
// Reset (arst_n low, asynchronous): reception idle, queue and output empty,
//   registers back to identifier 0, service 0, limit 4095, timeout 1000.
`default_nettype none
module isotp_rx_reassembler_core #(
	parameter int JOB_DEPTH = 4
) (
	input  wire            clk,
	input  wire            arst_n,
	isotp_item_if.sink     item,
	isotp_result_if.source result,
	input  wire            wr_en,
	input  wire [1:0]      wr_index,
	input  wire [28:0]     wr_data
);

	isotp_pkg::cfg_t cfg_q;
	isotp_pkg::job_t push_job, head_job;
	logic            job_push, job_pop, job_full, job_empty;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.resp_id <= '0;
			cfg_q.req_sid <= '0;
			cfg_q.limit   <= isotp_pkg::LIMIT_RESET;
			cfg_q.timeout <= isotp_pkg::TIMEOUT_RESET;
		end else if (wr_en) begin
			unique case (isotp_pkg::cfg_index_t'(wr_index))
				isotp_pkg::CFG_RESP_ID: cfg_q.resp_id <= wr_data;
				isotp_pkg::CFG_REQ_SID: cfg_q.req_sid <= wr_data[7:0];
				isotp_pkg::CFG_LIMIT:   cfg_q.limit   <= wr_data[11:0];
				isotp_pkg::CFG_TIMEOUT: cfg_q.timeout <= wr_data[15:0];
				default: begin
				end
			endcase
		end
	end

	isotp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cfg      (cfg_q),
		.job_full (job_full),
		.job_push (job_push),
		.job      (push_job)
	);

	isotp_job_fifo #(
		.DEPTH (JOB_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wr_job (push_job),
		.pop    (job_pop),
		.head   (head_job),
		.full   (job_full),
		.empty  (job_empty)
	);

	isotp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head_job),
		.empty  (job_empty),
		.pop    (job_pop),
		.result (result)
	);

	// no job is produced while the queue is full
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !job_full)
		else $error("job pushed into full queue");

	// a status-only word always closes its run and carries an event
	a_bare_word: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.byte_valid |->
			result.run_last && (result.message_end || result.flow_control_request))
		else $error("status word without event");

	// message end only on the last word of a run
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.message_end |-> result.run_last)
		else $error("message end before run end");

	// status is nonzero exactly on message end
	a_status_end: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |->
			(result.message_end == (result.message_status != isotp_pkg::ST_RUNNING)))
		else $error("status and message end disagree");

endmodule
`default_nettype wire

// ===== hdl/isotp_front.sv =====
`default_nettype none
module isotp_front (
	input  wire                 clk,
	input  wire                 arst_n,
	isotp_item_if.sink          item,
	input  isotp_pkg::cfg_t     cfg,
	input  wire                 job_full,
	output logic                job_push,
	output isotp_pkg::job_t     job
);

	// reception state
	logic        multi_q, multi_d;
	logic        disc_q, disc_d;
	logic        neg_q, neg_d;
	logic [11:0] len_q, len_d;
	logic [11:0] rx_q, rx_d;
	logic [15:0] idle_q, idle_d;

	logic        accept;
	logic [3:0]  flen;
	logic [7:0]  d [8];
	logic [3:0]  pci;
	logic [7:0]  sid_target;
	logic        sf_sid_ok, ff_sid_ok;
	logic [3:0]  sf_len;
	logic        sf_bad;
	logic [11:0] ff_total;
	logic [2:0]  ff_room, ff_copy;
	logic        ff_whole;
	logic [2:0]  cf_room, cf_chunk;
	logic [11:0] cf_rem, cf_sum;
	logic [15:0] idle_inc;

	assign item.ready = !job_full;
	assign accept     = item.valid && item.ready;

	// frame decode
	always_comb begin
		flen = (item.frame_length > isotp_pkg::MAX_FRAME_LEN) ?
			isotp_pkg::MAX_FRAME_LEN : item.frame_length;
		d[0] = item.byte0;
		d[1] = item.byte1;
		d[2] = item.byte2;
		d[3] = item.byte3;
		d[4] = item.byte4;
		d[5] = item.byte5;
		d[6] = item.byte6;
		d[7] = item.byte7;
	end

	assign pci        = d[0][7:4];
	assign sid_target = cfg.req_sid + isotp_pkg::SID_POS_OFFSET;
	assign sf_sid_ok  = (d[1] == isotp_pkg::SID_NEGATIVE) || (d[1] == sid_target);
	assign ff_sid_ok  = (d[2] == isotp_pkg::SID_NEGATIVE) || (d[2] == sid_target);

	// single frame checks
	assign sf_len = d[0][3:0];
	assign sf_bad = (flen < 4'd2) || (sf_len == 4'd0) || (sf_len > flen - 4'd1) ||
		({8'd0, sf_len} > cfg.limit);

	// first frame sizing
	assign ff_total = {d[0][3:0], d[1]};
	assign ff_room  = 3'(flen - 4'd2);
	assign ff_copy  = ({9'd0, ff_room} > ff_total) ? ff_total[2:0] : ff_room;
	assign ff_whole = ({9'd0, ff_copy} >= ff_total);

	// consecutive frame sizing
	assign cf_room  = 3'(flen - 4'd1);
	assign cf_rem   = len_q - rx_q;
	assign cf_chunk = ({9'd0, cf_room} > cf_rem) ? cf_rem[2:0] : cf_room;
	assign cf_sum   = rx_q + {9'd0, cf_chunk};

	assign idle_inc = (idle_q != 16'hFFFF) ? idle_q + 16'd1 : idle_q;

	// next state and job
	always_comb begin
		multi_d  = multi_q;
		disc_d   = disc_q;
		neg_d    = neg_q;
		len_d    = len_q;
		rx_d     = rx_q;
		idle_d   = idle_q;
		job_push = 1'b0;
		job      = '0;
		job.status = isotp_pkg::ST_RUNNING;
		for (int i = 0; i < 7; i++) begin
			job.data[i] = d[i + 1];
		end
		if (accept) begin
			if (item.command == isotp_pkg::CMD_TICK) begin
				if (multi_q) begin
					idle_d = idle_inc;
					if (idle_inc >= cfg.timeout) begin
						job_push    = 1'b1;
						job.msg_end = 1'b1;
						job.status  = isotp_pkg::ST_TIMEOUT;
						multi_d = 1'b0; disc_d = 1'b0; neg_d = 1'b0;
						len_d = '0; rx_d = '0; idle_d = '0;
					end
				end
			end else begin
				if (multi_q) begin
					idle_d = '0;
				end
				if (item.frame_identifier == cfg.resp_id) begin
					if (!multi_q) begin
						unique case (pci)
							isotp_pkg::PCI_SF: begin
								if (sf_bad) begin
									job_push    = 1'b1;
									job.msg_end = 1'b1;
									job.status  = isotp_pkg::ST_LENGTH_ERROR;
								end else if (sf_sid_ok) begin
									job_push    = 1'b1;
									job.nbytes  = sf_len[2:0];
									job.msg_end = 1'b1;
									job.status  = (d[1] == isotp_pkg::SID_NEGATIVE) ?
										isotp_pkg::ST_NEGATIVE : isotp_pkg::ST_POSITIVE;
								end
							end
							isotp_pkg::PCI_FF: begin
								job_push = 1'b1;
								if (flen < 4'd3 || ff_total == 12'd0 ||
										ff_total > cfg.limit) begin
									job.msg_end = 1'b1;
									job.status  = isotp_pkg::ST_LENGTH_ERROR;
								end else begin
									job.fc = 1'b1;
									for (int i = 0; i < 6; i++) begin
										job.data[i] = d[i + 2];
									end
									job.data[6] = 8'd0;
									if (ff_sid_ok) begin
										job.nbytes = ff_copy;
										if (ff_whole) begin
											job.msg_end = 1'b1;
											job.status  =
												(d[2] == isotp_pkg::SID_NEGATIVE) ?
												isotp_pkg::ST_NEGATIVE :
												isotp_pkg::ST_POSITIVE;
										end
									end
									if (!ff_whole) begin
										multi_d = 1'b1;
										disc_d  = !ff_sid_ok;
										neg_d   = (d[2] == isotp_pkg::SID_NEGATIVE);
										len_d   = ff_total;
										rx_d    = {9'd0, ff_copy};
										idle_d  = '0;
									end
								end
							end
							default: begin
							end
						endcase
					end else if (pci == isotp_pkg::PCI_CF && flen > 4'd1) begin
						rx_d = cf_sum;
						if (!disc_q) begin
							job_push   = 1'b1;
							job.nbytes = cf_chunk;
							job.base   = rx_q;
						end
						if (cf_sum >= len_q) begin
							job.msg_end = 1'b1;
							job.status  = neg_q ? isotp_pkg::ST_NEGATIVE :
								isotp_pkg::ST_POSITIVE;
							multi_d = 1'b0; disc_d = 1'b0; neg_d = 1'b0;
							len_d = '0; rx_d = '0; idle_d = '0;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			multi_q <= 1'b0;
			disc_q  <= 1'b0;
			neg_q   <= 1'b0;
			len_q   <= '0;
			rx_q    <= '0;
			idle_q  <= '0;
		end else begin
			multi_q <= multi_d;
			disc_q  <= disc_d;
			neg_q   <= neg_d;
			len_q   <= len_d;
			rx_q    <= rx_d;
			idle_q  <= idle_d;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/isotp_job_fifo.sv =====
`default_nettype none
module isotp_job_fifo #(
	parameter int DEPTH = 4
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             push,
	input  isotp_pkg::job_t wr_job,
	input  wire             pop,
	output isotp_pkg::job_t head,
	output logic            full,
	output logic            empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	isotp_pkg::job_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/isotp_back.sv =====
`default_nettype none
module isotp_back (
	input  wire             clk,
	input  wire             arst_n,
	input  isotp_pkg::job_t head,
	input  wire             empty,
	output logic            pop,
	isotp_result_if.source  result
);

	logic [2:0]  k_q;
	logic [2:0]  n_last;
	logic        last;
	logic        emit;

	logic        out_v_q;
	logic        bv_q;
	logic [7:0]  byte_q;
	logic [11:0] idx_q;
	logic        fc_q;
	logic        end_q;
	logic [2:0]  st_q;
	logic        rl_q;

	// a job with no bytes still gives one status word
	assign n_last = (head.nbytes == 3'd0) ? 3'd0 : head.nbytes - 3'd1;
	assign last   = (k_q == n_last);
	assign emit   = !empty && (!out_v_q || result.ready);
	assign pop    = emit && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (emit) begin
				k_q <= last ? 3'd0 : k_q + 3'd1;
			end
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (emit) begin
			bv_q   <= (head.nbytes != 3'd0);
			byte_q <= (head.nbytes != 3'd0) ? head.data[k_q] : 8'd0;
			idx_q  <= (head.nbytes != 3'd0) ? head.base + {9'd0, k_q} : 12'd0;
			fc_q   <= last && head.fc;
			end_q  <= last && head.msg_end;
			st_q   <= last ? head.status : isotp_pkg::ST_RUNNING;
			rl_q   <= last;
		end
	end

	assign result.valid                = out_v_q;
	assign result.byte_valid           = bv_q;
	assign result.payload_byte         = byte_q;
	assign result.payload_index        = idx_q;
	assign result.flow_control_request = fc_q;
	assign result.message_end          = end_q;
	assign result.message_status       = st_q;
	assign result.run_last             = rl_q;

endmodule
`default_nettype wire
